### rtl/core/tars_pkg.sv
// Shared types and constants for the teach-and-replay sequencer.
package tars_pkg;

  localparam int JOY_BITS      = 10;
  localparam int JOY_LANES     = 5;
  localparam int AXIS_BITS     = 3;
  localparam int MAX_EVENTS    = 20;
  localparam int EVC_BITS      = 5;
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = 10;

  typedef logic [JOY_BITS-1:0] joy_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_JOG_HIGH = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_JOG_LOW  = 4'd1;

  localparam joy_t JOG_HIGH_RESET = 10'd700;
  localparam joy_t JOG_LOW_RESET  = 10'd250;

  // Caller of a homing pass
  localparam logic [1:0] HP_REC  = 2'd0;
  localparam logic [1:0] HP_PLAY = 2'd1;
  localparam logic [1:0] HP_HOME = 2'd2;

  // One buffered input item
  typedef struct packed {
    joy_t [JOY_LANES-1:0] joy;
    logic                 record_press;
    logic                 capture_press;
    logic                 play_press;
    logic                 home_press;
  } tars_item_t;

  // Command from the sequencer to one axis lane
  typedef struct packed {
    logic step_en;
    logic step_up;
    logic rem_step;
    logic rem_load;
  } tars_lane_cmd_t;

  // Status reported by one axis lane
  typedef struct packed {
    logic jog_up;
    logic jog_dn;
    logic pos_zero;
    logic pos_neg;
    logic pos_unit;
    logic rem_zero;
    logic rem_neg;
    logic rem_unit;
  } tars_lane_st_t;

endpackage

### rtl/core/tars_if.sv
// Channel interfaces: input items, step results and configuration writes.
interface tars_in_if import tars_pkg::*; ();
  logic valid;
  logic ready;
  joy_t joy_base;
  joy_t joy_shoulder;
  joy_t joy_elbow;
  joy_t joy_wrist;
  joy_t joy_hand;
  logic record_press;
  logic capture_press;
  logic play_press;
  logic home_press;

  modport source (output valid, joy_base, joy_shoulder, joy_elbow, joy_wrist, joy_hand,
                  record_press, capture_press, play_press, home_press, input ready);
  modport sink (input valid, joy_base, joy_shoulder, joy_elbow, joy_wrist, joy_hand,
                record_press, capture_press, play_press, home_press, output ready);
endinterface

interface tars_out_if import tars_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [AXIS_BITS-1:0] axis;
  logic                 direction;
  logic                 last;

  modport source (output valid, axis, direction, last, input ready);
  modport sink (input valid, axis, direction, last, output ready);
endinterface

interface tars_cfg_if import tars_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/core/tars_lane.sv
// One axis lane: position and remaining-step counters with jog and zero detection.
module tars_lane import tars_pkg::*; #(
  parameter int POS_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  joy_t                sample,
  input  logic                sample_en,
  input  joy_t                thr_hi,
  input  joy_t                thr_lo,
  input  tars_lane_cmd_t      cmd,
  input  logic [POS_BITS-1:0] rem_load_val,
  output logic [POS_BITS-1:0] pos,
  output tars_lane_st_t       st
);

  localparam logic [POS_BITS-1:0] ONE = POS_BITS'(1);

  logic [POS_BITS-1:0] pos_r;
  logic [POS_BITS-1:0] rem_r;

  // Counters wrap modulo 2^POS_BITS
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rem_r <= '0;
    end else begin
      if (cmd.step_en) begin
        pos_r <= cmd.step_up ? pos_r + ONE : pos_r - ONE;
      end
      if (cmd.rem_load) begin
        rem_r <= rem_load_val;
      end else if (cmd.rem_step) begin
        rem_r <= cmd.step_up ? rem_r + ONE : rem_r - ONE;
      end
    end
  end

  // Jog decision and zero, sign and one-step-from-zero flags
  always_comb begin
    st.jog_up   = sample_en && (sample > thr_hi);
    st.jog_dn   = sample_en && !(sample > thr_hi) && (sample < thr_lo);
    st.pos_zero = (pos_r == '0);
    st.pos_neg  = pos_r[POS_BITS-1];
    st.pos_unit = (pos_r == ONE) || (pos_r == '1);
    st.rem_zero = (rem_r == '0);
    st.rem_neg  = rem_r[POS_BITS-1];
    st.rem_unit = (rem_r == ONE) || (rem_r == '1);
  end

  assign pos = pos_r;

endmodule

### rtl/core/teach_and_replay_axis_sequencer_top.sv
// Teach-and-replay sequencer top: tick sequencer, axis lanes, pose store and output stage.
// One input item is one control tick. The sequencer walks the tick one axis per cycle,
// unless output backpressure stalls it, over a row of axis lanes: jogging over every axis,
// the control states (one more after a record homing pass and one more per pose phase),
// a step for every axis visited by a homing or playback pass, and a load of each pose
// from the pose store in states LDA, LDB and LDC (one memory read port). A one-item input
// buffer takes the next tick while the current one runs; a pending-event register and an
// output register let the final event of the tick carry last. No clearing pass after reset.
module teach_and_replay_axis_sequencer_top import tars_pkg::*; #(
  parameter int NUM_AXES  = 5,
  parameter int NUM_POSES = 2,
  parameter int POS_BITS  = 32
) (
  input logic       clk,
  input logic       rst_n,
  tars_in_if.sink   in_ch,
  tars_out_if.source out_ch,
  tars_cfg_if.sink  cfg_ch
);

  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
  localparam int SW  = $clog2(NUM_POSES + 1);
  localparam int PW  = (NUM_POSES > 1) ? $clog2(NUM_POSES) : 1;
  localparam int ROW = NUM_AXES * POS_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_JOG   = 4'd1;
  localparam logic [3:0] S_REC   = 4'd2;
  localparam logic [3:0] S_RCHK  = 4'd3;
  localparam logic [3:0] S_CAP   = 4'd4;
  localparam logic [3:0] S_PLAY  = 4'd5;
  localparam logic [3:0] S_PCHK  = 4'd6;
  localparam logic [3:0] S_LDA   = 4'd7;
  localparam logic [3:0] S_LDB   = 4'd8;
  localparam logic [3:0] S_LDC   = 4'd9;
  localparam logic [3:0] S_PPASS = 4'd10;
  localparam logic [3:0] S_HOMEP = 4'd11;
  localparam logic [3:0] S_HPASS = 4'd12;
  localparam logic [3:0] S_FLUSH = 4'd13;

  // Configuration
  joy_t thr_hi_r, thr_lo_r;

  // Input buffer and current tick
  logic       buf_valid_r;
  tars_item_t buf_r, cur_r;

  // Sequencer state
  logic [3:0]          st_r, st_nxt;
  logic [AXW-1:0]      ax_r, ax_nxt;
  logic [1:0]          ctx_r, ctx_nxt;
  logic [EVC_BITS-1:0] ev_cnt_r;
  logic                recording_r, recording_nxt;
  logic                rec_fin_r, rec_fin_nxt;
  logic [SW-1:0]       cap_slot_r, cap_slot_nxt;
  logic                playing_r, playing_nxt;
  logic [SW-1:0]       phase_r, phase_nxt;
  logic                loaded_r, loaded_nxt;
  logic                homing_r, homing_nxt;

  // Sequencer actions
  logic          want, want_up, rem_step, rem_load, flush, take, cap_wr, to_latch;
  logic          can_emit, can_push, stall, fire, push;
  logic [PW-1:0] rd_addr;

  // Pending event and output register
  logic                 pend_valid_r;
  logic [AXIS_BITS-1:0] pend_axis_r;
  logic                 pend_dir_r;
  logic                 out_valid_r;
  logic [AXIS_BITS-1:0] out_axis_r;
  logic                 out_dir_r;
  logic                 out_last_r;

  // Pose store
  logic [ROW-1:0] pose_mem [NUM_POSES];
  logic           pose_vld_r [NUM_POSES];
  logic [ROW-1:0] rd_data_r;
  logic           rd_vld_r;
  logic [ROW-1:0] rd_row, to_row_r, pos_row;

  // Lanes
  tars_lane_cmd_t      lane_cmd [NUM_AXES];
  tars_lane_st_t       lane_st  [NUM_AXES];
  logic [POS_BITS-1:0] lane_pos [NUM_AXES];
  logic [POS_BITS-1:0] rem_ld_val [NUM_AXES];
  tars_lane_st_t       sel_st;
  logic                last_ax;
  logic                all_zero;

  // Configuration writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_hi_r <= JOG_HIGH_RESET;
      thr_lo_r <= JOG_LOW_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_JOG_HIGH: thr_hi_r <= cfg_ch.data;
        CFG_JOG_LOW:  thr_lo_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input buffer: free while a tick runs
  assign in_ch.ready = !buf_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else if (take) begin
      buf_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      buf_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      buf_r.joy[0]        <= in_ch.joy_base;
      buf_r.joy[1]        <= in_ch.joy_shoulder;
      buf_r.joy[2]        <= in_ch.joy_elbow;
      buf_r.joy[3]        <= in_ch.joy_wrist;
      buf_r.joy[4]        <= in_ch.joy_hand;
      buf_r.record_press  <= in_ch.record_press;
      buf_r.capture_press <= in_ch.capture_press;
      buf_r.play_press    <= in_ch.play_press;
      buf_r.home_press    <= in_ch.home_press;
    end
    if (take) begin
      cur_r <= buf_r;
    end
  end

  // Axis lanes
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    joy_t sample;
    logic sample_en;

    if (a < JOY_LANES) begin : g_joy
      assign sample    = cur_r.joy[a];
      assign sample_en = 1'b1;
    end else begin : g_nojoy
      assign sample    = '0;
      assign sample_en = 1'b0;
    end

    assign lane_cmd[a].step_en  = fire && (ax_r == AXW'(a));
    assign lane_cmd[a].step_up  = want_up;
    assign lane_cmd[a].rem_step = fire && rem_step && (ax_r == AXW'(a));
    assign lane_cmd[a].rem_load = rem_load && !stall;

    assign pos_row[a*POS_BITS +: POS_BITS] = lane_pos[a];
    // Remaining steps: previous pose minus target pose
    assign rem_ld_val[a] = ((phase_r <= SW'(1)) ? '0 : rd_row[a*POS_BITS +: POS_BITS])
                           - to_row_r[a*POS_BITS +: POS_BITS];

    tars_lane #(.POS_BITS(POS_BITS)) u_lane (
      .clk          (clk),
      .rst_n        (rst_n),
      .sample       (sample),
      .sample_en    (sample_en),
      .thr_hi       (thr_hi_r),
      .thr_lo       (thr_lo_r),
      .cmd          (lane_cmd[a]),
      .rem_load_val (rem_ld_val[a]),
      .pos          (lane_pos[a]),
      .st           (lane_st[a])
    );
  end

  // Merge: selected lane and all-home detect
  assign sel_st  = lane_st[ax_r];
  assign last_ax = (ax_r == AXW'(NUM_AXES - 1));

  always_comb begin
    all_zero = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      all_zero = all_zero && lane_st[a].pos_zero;
    end
  end

  // Pose store with registered read
  assign rd_row = rd_vld_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cap_wr) begin
      pose_mem[cap_slot_r[PW-1:0]] <= pos_row;
    end
    rd_data_r <= pose_mem[rd_addr];
    rd_vld_r  <= pose_vld_r[rd_addr];
    if (to_latch) begin
      to_row_r <= rd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POSES; p++) begin
        pose_vld_r[p] <= 1'b0;
      end
    end else if (cap_wr) begin
      pose_vld_r[cap_slot_r[PW-1:0]] <= 1'b1;
    end
  end

  // Tick sequencer
  assign can_emit = (ev_cnt_r < EVC_BITS'(MAX_EVENTS));
  assign can_push = !out_valid_r || out_ch.ready;

  always_comb begin
    logic rec_n, fin_n, play_n, hom_n, pass_ok, done;
    logic [SW-1:0] ph_n;

    rec_n   = recording_r;
    fin_n   = rec_fin_r;
    play_n  = playing_r;
    hom_n   = homing_r;
    ph_n    = phase_r;
    pass_ok = 1'b0;
    done    = 1'b0;

    st_nxt        = st_r;
    ax_nxt        = ax_r;
    ctx_nxt       = ctx_r;
    recording_nxt = recording_r;
    rec_fin_nxt   = rec_fin_r;
    cap_slot_nxt  = cap_slot_r;
    playing_nxt   = playing_r;
    phase_nxt     = phase_r;
    loaded_nxt    = loaded_r;
    homing_nxt    = homing_r;
    want          = 1'b0;
    want_up       = 1'b0;
    rem_step      = 1'b0;
    rem_load      = 1'b0;
    flush         = 1'b0;
    take          = 1'b0;
    cap_wr        = 1'b0;
    to_latch      = 1'b0;
    rd_addr       = '0;

    unique case (st_r)
      S_IDLE: begin
        if (buf_valid_r) begin
          take   = 1'b1;
          ax_nxt = '0;
          st_nxt = S_JOG;
        end
      end
      S_JOG: begin
        if (sel_st.jog_up) begin
          want    = 1'b1;
          want_up = 1'b1;
        end else if (sel_st.jog_dn) begin
          want = 1'b1;
        end
        if (last_ax) begin
          st_nxt = S_REC;
        end else begin
          ax_nxt = ax_r + AXW'(1);
        end
      end
      S_REC: begin
        if (cur_r.record_press) begin
          if (!recording_r) begin
            rec_n = 1'b1;
          end else begin
            fin_n = 1'b1;
          end
        end
        recording_nxt = rec_n;
        rec_fin_nxt   = fin_n;
        if (rec_n && fin_n) begin
          st_nxt  = S_HPASS;
          ctx_nxt = HP_REC;
          ax_nxt  = '0;
        end else begin
          st_nxt = S_CAP;
        end
      end
      S_RCHK: begin
        if (all_zero) begin
          recording_nxt = 1'b0;
          rec_fin_nxt   = 1'b0;
          cap_slot_nxt  = '0;
        end
        st_nxt = S_CAP;
      end
      S_CAP: begin
        if (recording_r && cur_r.capture_press && (cap_slot_r < SW'(NUM_POSES))) begin
          cap_wr       = 1'b1;
          cap_slot_nxt = cap_slot_r + SW'(1);
        end
        st_nxt = S_PLAY;
      end
      S_PLAY: begin
        if (cur_r.play_press) begin
          play_n     = !playing_r;
          ph_n       = '0;
          loaded_nxt = 1'b0;
        end
        playing_nxt = play_n;
        phase_nxt   = ph_n;
        if (play_n && (ph_n == '0)) begin
          st_nxt  = S_HPASS;
          ctx_nxt = HP_PLAY;
          ax_nxt  = '0;
        end else begin
          st_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (playing_r && (phase_r != '0) && (phase_r <= SW'(NUM_POSES))) begin
          if (!loaded_r) begin
            st_nxt = S_LDA;
          end else begin
            ax_nxt = '0;
            st_nxt = S_PPASS;
          end
        end else begin
          st_nxt = S_HOMEP;
        end
      end
      S_LDA: begin
        rd_addr = PW'(phase_r - SW'(1));
        st_nxt  = S_LDB;
      end
      S_LDB: begin
        to_latch = 1'b1;
        rd_addr  = PW'(phase_r - SW'(2));
        st_nxt   = S_LDC;
      end
      S_LDC: begin
        rem_load   = 1'b1;
        loaded_nxt = 1'b1;
        ax_nxt     = '0;
        st_nxt     = S_PPASS;
      end
      S_PPASS: begin
        if (!sel_st.rem_zero) begin
          want     = 1'b1;
          want_up  = sel_st.rem_neg;
          rem_step = 1'b1;
          if (!(can_emit && sel_st.rem_unit)) begin
            st_nxt = S_HOMEP;
          end else if (last_ax) begin
            pass_ok = 1'b1;
          end else begin
            ax_nxt = ax_r + AXW'(1);
          end
        end else if (last_ax) begin
          pass_ok = 1'b1;
        end else begin
          ax_nxt = ax_r + AXW'(1);
        end
        // Pose reached: next phase within the same tick
        if (pass_ok) begin
          loaded_nxt = 1'b0;
          if (phase_r >= SW'(NUM_POSES)) begin
            playing_nxt = 1'b0;
            phase_nxt   = '0;
          end else begin
            phase_nxt = phase_r + SW'(1);
          end
          st_nxt = S_PCHK;
        end
      end
      S_HOMEP: begin
        if (cur_r.home_press) begin
          hom_n = !homing_r;
        end
        homing_nxt = hom_n;
        if (hom_n) begin
          st_nxt  = S_HPASS;
          ctx_nxt = HP_HOME;
          ax_nxt  = '0;
        end else begin
          st_nxt = S_FLUSH;
        end
      end
      S_HPASS: begin
        if (sel_st.pos_zero) begin
          if (last_ax) begin
            homing_nxt = 1'b0;
            if (playing_r && (phase_r == '0)) begin
              phase_nxt  = SW'(1);
              loaded_nxt = 1'b0;
            end
            done = 1'b1;
          end else begin
            ax_nxt = ax_r + AXW'(1);
          end
        end else begin
          want    = 1'b1;
          want_up = sel_st.pos_neg;
          if (!(can_emit && sel_st.pos_unit) || last_ax) begin
            done = 1'b1;
          end else begin
            ax_nxt = ax_r + AXW'(1);
          end
        end
        if (done) begin
          case (ctx_r)
            HP_REC:  st_nxt = S_RCHK;
            HP_PLAY: st_nxt = S_PCHK;
            default: st_nxt = S_FLUSH;
          endcase
        end
      end
      S_FLUSH: begin
        flush  = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // A step or the end-of-tick flush waits while the pending event cannot move to the output register
  assign stall = pend_valid_r && !can_push && ((want && can_emit) || flush);
  assign fire  = want && can_emit && !stall;
  assign push  = pend_valid_r && can_push && (fire || flush);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ax_r        <= '0;
      ctx_r       <= HP_REC;
      ev_cnt_r    <= '0;
      recording_r <= 1'b0;
      rec_fin_r   <= 1'b0;
      cap_slot_r  <= '0;
      playing_r   <= 1'b0;
      phase_r     <= '0;
      loaded_r    <= 1'b0;
      homing_r    <= 1'b0;
    end else if (!stall) begin
      st_r        <= st_nxt;
      ax_r        <= ax_nxt;
      ctx_r       <= ctx_nxt;
      recording_r <= recording_nxt;
      rec_fin_r   <= rec_fin_nxt;
      cap_slot_r  <= cap_slot_nxt;
      playing_r   <= playing_nxt;
      phase_r     <= phase_nxt;
      loaded_r    <= loaded_nxt;
      homing_r    <= homing_nxt;
      if (take) begin
        ev_cnt_r <= '0;
      end else if (fire) begin
        ev_cnt_r <= ev_cnt_r + EVC_BITS'(1);
      end
    end
  end

  // Pending event: held back one step so the final item of a tick carries last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (fire) begin
      pend_valid_r <= 1'b1;
    end else if (flush && can_push) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_axis_r <= AXIS_BITS'(ax_r);
      pend_dir_r  <= !want_up;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_axis_r <= pend_axis_r;
      out_dir_r  <= pend_dir_r;
      out_last_r <= flush;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.axis      = out_axis_r;
  assign out_ch.direction = out_dir_r;
  assign out_ch.last      = out_last_r;

  // Checks
  a_ev_budget: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= EVC_BITS'(MAX_EVENTS))
    else $error("step budget exceeded");

  a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !pend_valid_r)
    else $error("pending item left at end of tick");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= SW'(NUM_POSES))
    else $error("play phase out of range");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cap_slot_r <= SW'(NUM_POSES))
    else $error("capture slot out of range");

endmodule
